### rtl/stcb_pkg.sv
// Shared types, constants and helpers for the spanning-tree configuration engine.
// No dependencies.
`default_nettype none
package stcb_pkg;

	localparam int STCB_NUM_PORTS = 8;

	localparam logic [63:0] RST_BRIDGE_ID = 64'd0;
	localparam logic [3:0]  RST_PORTS     = 4'd8;
	localparam logic [7:0]  RST_PRIO      = 8'd128;
	localparam logic [15:0] RST_LINK_COST = 16'd1;

	localparam logic [1:0] REG_BRIDGE_ID = 2'd0;
	localparam logic [1:0] REG_PORTS     = 2'd1;
	localparam logic [1:0] REG_PRIO      = 2'd2;
	localparam logic [1:0] REG_LINK_COST = 2'd3;

	localparam logic OP_RX_CONFIG = 1'b0;
	localparam logic OP_HELLO     = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [2:0]  rx_port;
		logic [63:0] rx_root_id;
		logic [31:0] rx_root_cost;
		logic [63:0] rx_bridge_id;
		logic [15:0] rx_port_id;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  tx_port;
		logic [63:0] tx_root_id;
		logic [31:0] tx_root_cost;
		logic [15:0] tx_port_id;
		logic        is_root_bridge;
		logic        last;
	} out_item_t;

	// field order makes a plain unsigned compare lexicographic
	typedef struct packed {
		logic [63:0] root;
		logic [31:0] cost;
		logic [63:0] bridge;
		logic [15:0] ident;
	} vec_t;

	function automatic logic [15:0] own_ident(input logic [7:0] prio, input logic [7:0] idx);
		return {prio, 8'h00} + {8'h00, 8'(idx + 8'd1)};
	endfunction

	function automatic logic vec_less(input vec_t a, input vec_t b);
		return a < b;
	endfunction

endpackage
`default_nettype wire

### rtl/spanning_tree_config_bpdu_engine.sv
// Spanning-tree configuration engine. Hello tick: one send pass over the N active ports.
// Received config not better than the port's vector: compare, then at most one reply; better:
// root selection pass, refresh pass and send pass over the ports, each reading a port's vector
// from the registered vector RAM before evaluating it. One item at a time; output stall extends it.
// Reset and any register write restore every port vector to its own-bridge value.
`default_nettype none
module spanning_tree_config_bpdu_engine import stcb_pkg::*; #(
	parameter int NUM_PORTS = STCB_NUM_PORTS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);
	localparam int IW = $clog2(NUM_PORTS);
	localparam int CW = $clog2(NUM_PORTS + 1);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_CMP    = 10'b0000000010,
		S_SEL_RD = 10'b0000000100,
		S_SEL_EV = 10'b0000001000,
		S_SEL_FN = 10'b0000010000,
		S_REF_RD = 10'b0000100000,
		S_REF_EV = 10'b0001000000,
		S_SND_RD = 10'b0010000000,
		S_SND_EV = 10'b0100000000,
		S_FLUSH  = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [63:0] bid_q;
	logic [3:0]  pu_q;
	logic [7:0]  prio_q;
	logic [15:0] lcost_q;

	logic [63:0] cur_root_q;
	logic [31:0] cur_cost_q;
	logic [IW-1:0] rp_idx_q;
	logic        rpv_q;

	in_item_t    rx_q;
	logic [CW-1:0] i_q;
	vec_t        best_q;
	logic [IW-1:0] best_idx_q;
	logic        found_q;
	out_item_t   pend_q;
	logic        pend_v_q;
	logic        ov_q;
	out_item_t   od_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[4:3])
			REG_BRIDGE_ID: prdata = bid_q;
			REG_PORTS:     prdata = {60'd0, pu_q};
			REG_PRIO:      prdata = {56'd0, prio_q};
			REG_LINK_COST: prdata = {48'd0, lcost_q};
			default:       prdata = '0;
		endcase
	end

	logic [CW-1:0] np;
	always_comb begin
		if (pu_q == 4'd0)
			np = CW'(1);
		else if (32'(pu_q) > NUM_PORTS)
			np = CW'(NUM_PORTS);
		else
			np = CW'(pu_q);
	end

	// vector store
	logic          we;
	logic [IW-1:0] waddr;
	vec_t          wdata;
	logic [IW-1:0] raddr;
	vec_t          ent;
	logic [IW-1:0] idx;

	assign idx = i_q[IW-1:0];

	stcb_vec_store #(.NUM_PORTS(NUM_PORTS)) u_store (
		.clk(clk), .arst_n(arst_n), .clear(cfg_wr), .we(we), .waddr(waddr),
		.wdata(wdata), .raddr(raddr), .bridge_id(bid_q), .prio(prio_q), .rdata(ent)
	);

	logic [IW-1:0] rx_idx_in, rx_idx;
	assign rx_idx_in = IW'(in_data.rx_port);
	assign rx_idx    = IW'(rx_q.rx_port);
	assign raddr = (state_q == S_IDLE) ? rx_idx_in : idx;

	logic [15:0] own_i;
	logic        des_i;
	logic        emit_ok;
	vec_t        rx_vec;
	vec_t        cur_vec;
	logic        ref_skip;
	logic        rx_better;
	logic        in_acc;
	logic        out_free;
	logic        last_i;
	logic [32:0] cost_sum;

	assign own_i    = own_ident(prio_q, 8'(idx));
	assign des_i    = (ent.bridge == bid_q) && (ent.ident == own_i);
	assign emit_ok  = (cur_root_q == bid_q) || rpv_q;
	assign rx_vec   = '{root: rx_q.rx_root_id, cost: rx_q.rx_root_cost,
		bridge: rx_q.rx_bridge_id, ident: rx_q.rx_port_id};
	assign cur_vec  = '{root: cur_root_q, cost: cur_cost_q, bridge: bid_q, ident: own_i};
	assign ref_skip = rpv_q && (idx == rp_idx_q);
	assign rx_better = vec_less(rx_vec, ent);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !ov_q || !out_stall;
	assign last_i   = (i_q + CW'(1)) == np;
	assign cost_sum = {1'b0, best_q.cost} + {17'd0, lcost_q};

	assign in_stall = (state_q != S_IDLE);

	function automatic out_item_t mk_item(input logic [IW-1:0] p, input logic [63:0] root,
			input logic [31:0] cost, input logic [7:0] prio, input logic isroot);
		return '{tx_port: 3'(p), tx_root_id: root, tx_root_cost: cost,
			tx_port_id: own_ident(prio, 8'(p)), is_root_bridge: isroot, last: 1'b0};
	endfunction

	// store writes
	always_comb begin
		we = 1'b0;
		waddr = idx;
		wdata = ent;
		if (state_q == S_CMP) begin
			waddr = rx_idx;
			wdata = rx_vec;
			we = rx_better;
		end else if (state_q == S_REF_EV && !ref_skip) begin
			if (des_i) begin
				we = 1'b1;
				wdata.root = cur_root_q;
				wdata.cost = cur_cost_q;
			end else if (vec_less(cur_vec, ent)) begin
				we = 1'b1;
				wdata = cur_vec;
			end
		end
	end

	// output push
	logic      push;
	out_item_t push_d;
	out_item_t new_item;
	assign new_item = mk_item(idx, cur_root_q, cur_cost_q, prio_q, cur_root_q == bid_q);

	always_comb begin
		push = 1'b0;
		push_d = pend_q;
		if (state_q == S_SND_EV && des_i && emit_ok && pend_v_q && out_free)
			push = 1'b1;
		if (state_q == S_FLUSH && pend_v_q && out_free) begin
			push = 1'b1;
			push_d.last = 1'b1;
		end
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;

	always_ff @(posedge clk) begin
		if (in_acc)
			rx_q <= in_data;
		if (push)
			od_q <= push_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			bid_q      <= RST_BRIDGE_ID;
			pu_q       <= RST_PORTS;
			prio_q     <= RST_PRIO;
			lcost_q    <= RST_LINK_COST;
			cur_root_q <= RST_BRIDGE_ID;
			cur_cost_q <= '0;
			rp_idx_q   <= '0;
			rpv_q      <= 1'b0;
			i_q        <= '0;
			best_q     <= '0;
			best_idx_q <= '0;
			found_q    <= 1'b0;
			pend_q     <= '0;
			pend_v_q   <= 1'b0;
			ov_q       <= 1'b0;
		end else begin
			if (push)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;

			if (cfg_wr) begin
				unique case (paddr[4:3])
					REG_BRIDGE_ID: bid_q   <= pwdata;
					REG_PORTS:     pu_q    <= pwdata[3:0];
					REG_PRIO:      prio_q  <= pwdata[7:0];
					REG_LINK_COST: lcost_q <= pwdata[15:0];
					default: ;
				endcase
				cur_root_q <= (paddr[4:3] == REG_BRIDGE_ID) ? pwdata : bid_q;
				cur_cost_q <= '0;
				rp_idx_q   <= '0;
				rpv_q      <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					i_q <= '0;
					if (in_acc) begin
						if (in_data.operation == OP_HELLO)
							state_q <= S_SND_RD;
						else if (32'(in_data.rx_port) < 32'(np))
							state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (rx_better) begin
						found_q <= 1'b0;
						state_q <= S_SEL_RD;
					end else begin
						if (emit_ok) begin
							pend_q   <= mk_item(rx_idx, cur_root_q, cur_cost_q, prio_q,
								cur_root_q == bid_q);
							pend_v_q <= 1'b1;
						end
						state_q <= S_FLUSH;
					end
				end
				S_SEL_RD: state_q <= S_SEL_EV;
				S_SEL_EV: begin
					if (!des_i && (!found_q || vec_less(ent, best_q))) begin
						best_q     <= ent;
						best_idx_q <= idx;
						found_q    <= 1'b1;
					end
					i_q <= i_q + CW'(1);
					state_q <= last_i ? S_SEL_FN : S_SEL_RD;
				end
				S_SEL_FN: begin
					rpv_q <= found_q;
					if (found_q) begin
						rp_idx_q   <= best_idx_q;
						cur_root_q <= best_q.root;
						cur_cost_q <= cost_sum[32] ? 32'hFFFF_FFFF : cost_sum[31:0];
					end else begin
						rp_idx_q   <= '0;
						cur_root_q <= bid_q;
						cur_cost_q <= '0;
					end
					i_q <= '0;
					state_q <= S_REF_RD;
				end
				S_REF_RD: state_q <= S_REF_EV;
				S_REF_EV: begin
					if (last_i) begin
						i_q <= '0;
						state_q <= S_SND_RD;
					end else begin
						i_q <= i_q + CW'(1);
						state_q <= S_REF_RD;
					end
				end
				S_SND_RD: state_q <= S_SND_EV;
				S_SND_EV: begin
					// hold the previous item until we know whether it is the last
					if (!(des_i && emit_ok && pend_v_q && !out_free)) begin
						if (des_i && emit_ok) begin
							pend_q   <= new_item;
							pend_v_q <= 1'b1;
						end
						i_q <= i_q + CW'(1);
						state_q <= last_i ? S_FLUSH : S_SND_RD;
					end
				end
				S_FLUSH: begin
					if (!pend_v_q)
						state_q <= S_IDLE;
					else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/stcb_vec_store.sv
// Per-port priority vector store: synchronous RAM with a registered read.
// Entries never written since the last clear read as their reset vector. Uses stcb_pkg.
`default_nettype none
module stcb_vec_store import stcb_pkg::*; #(
	parameter int NUM_PORTS = STCB_NUM_PORTS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         clear,
	input  wire logic                         we,
	input  wire logic [$clog2(NUM_PORTS)-1:0] waddr,
	input  wire vec_t                         wdata,
	input  wire logic [$clog2(NUM_PORTS)-1:0] raddr,
	input  wire logic [63:0]                  bridge_id,
	input  wire logic [7:0]                   prio,
	output vec_t                              rdata
);
	localparam int IW = $clog2(NUM_PORTS);

	vec_t             mem [NUM_PORTS];
	logic [NUM_PORTS-1:0] vld_q;
	vec_t             rd_q;
	logic             rdv_q;
	logic [IW-1:0]    ra_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
		ra_q <= raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			rdv_q <= vld_q[raddr] && !(clear);
			if (clear)
				vld_q <= '0;
			else if (we)
				vld_q[waddr] <= 1'b1;
		end
	end

	always_comb begin
		if (rdv_q)
			rdata = rd_q;
		else
			rdata = '{root: bridge_id, cost: 32'd0, bridge: bridge_id,
				ident: own_ident(prio, 8'(ra_q))};
	end

endmodule
`default_nettype wire

### rtl/stcb_checker.sv
// Port-level checks for the spanning-tree configuration engine, bound to the top level.
// Uses stcb_pkg.
`default_nettype none
module stcb_checker import stcb_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire in_item_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_data,
	input wire logic      pready
);
	// a hello tick always walks the ports, so the input closes right after it
	a_busy_after_hello: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.operation == OP_HELLO |=> in_stall)
		else $error("input open after hello item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind spanning_tree_config_bpdu_engine stcb_checker u_stcb_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
	.out_data(out_data), .pready(pready)
);
`default_nettype wire

### bench/tb_spanning_tree_config_bpdu_engine.sv
// Testbench for spanning_tree_config_bpdu_engine: directed and random items over
// several register settings, checked against a predictor class. Depends on stcb_pkg.
`timescale 1ns / 1ps
module tb_spanning_tree_config_bpdu_engine;
	import stcb_pkg::*;

	class stp_predictor;
		bit [63:0] bid;
		bit [3:0]  nports;
		bit [7:0]  prio;
		bit [15:0] lcost;
		bit [63:0] proot[8];
		bit [31:0] pcost[8];
		bit [63:0] pbr[8];
		bit [15:0] pid[8];
		bit [63:0] croot;
		bit [31:0] ccost;
		int        rp_idx;
		bit        rp_ok;
		out_item_t tx_due[$];
		int        errors;

		function int active();
			if (nports == 0) return 1;
			if (nports > 8) return 8;
			return nports;
		endfunction

		function bit [15:0] ident(int i);
			return {prio, 8'h00} + 16'(i + 1);
		endfunction

		function bit desig(int i);
			return pbr[i] == bid && pid[i] == ident(i);
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++) begin
				proot[i] = bid;
				pcost[i] = 0;
				pbr[i] = bid;
				pid[i] = ident(i);
			end
			croot = bid;
			ccost = 0;
			rp_idx = 0;
			rp_ok = 0;
		endfunction

		function void set_reg(logic [1:0] idx, bit [63:0] val);
			case (idx)
				REG_BRIDGE_ID: bid = val;
				REG_PORTS:     nports = val[3:0];
				REG_PRIO:      prio = val[7:0];
				REG_LINK_COST: lcost = val[15:0];
			endcase
			restart();
		endfunction

		function void emit(int p, ref out_item_t batch[$]);
			out_item_t o;
			if (croot != bid && !rp_ok) return;
			o.tx_port = p[2:0];
			o.tx_root_id = croot;
			o.tx_root_cost = ccost;
			o.tx_port_id = ident(p);
			o.is_root_bridge = croot == bid;
			o.last = 0;
			batch.push_back(o);
		endfunction

		function void pick_root();
			int best;
			bit found;
			bit [32:0] sum;
			best = 0;
			found = 0;
			for (int i = 0; i < active(); i++) begin
				if (desig(i)) continue;
				if (!found || {proot[i], pcost[i], pbr[i], pid[i]}
						< {proot[best], pcost[best], pbr[best], pid[best]}) begin
					best = i;
					found = 1;
				end
			end
			if (!found) begin
				rp_ok = 0;
				rp_idx = 0;
				croot = bid;
				ccost = 0;
				return;
			end
			rp_ok = 1;
			rp_idx = best;
			croot = proot[best];
			sum = {1'b0, pcost[best]} + 33'(lcost);
			ccost = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		endfunction

		function void refresh();
			for (int i = 0; i < active(); i++) begin
				if (rp_ok && i == rp_idx) continue;
				if (desig(i)) begin
					pcost[i] = ccost;
					proot[i] = croot;
				end else if ({croot, ccost, bid, ident(i)}
						< {proot[i], pcost[i], pbr[i], pid[i]}) begin
					proot[i] = croot;
					pbr[i] = bid;
					pid[i] = ident(i);
					pcost[i] = ccost;
				end
			end
		endfunction

		function void note_input(in_item_t it);
			out_item_t batch[$];
			int p;
			p = it.rx_port;
			if (it.operation == OP_HELLO) begin
				for (int i = 0; i < active(); i++)
					if (desig(i)) emit(i, batch);
			end else begin
				if (p >= active()) return;
				if ({it.rx_root_id, it.rx_root_cost, it.rx_bridge_id, it.rx_port_id}
						< {proot[p], pcost[p], pbr[p], pid[p]}) begin
					proot[p] = it.rx_root_id;
					pcost[p] = it.rx_root_cost;
					pbr[p] = it.rx_bridge_id;
					pid[p] = it.rx_port_id;
					pick_root();
					refresh();
					for (int i = 0; i < active(); i++)
						if (desig(i)) emit(i, batch);
				end else
					emit(p, batch);
			end
			if (batch.size() > 0) batch[batch.size() - 1].last = 1;
			foreach (batch[k]) tx_due.push_back(batch[k]);
		endfunction

		task report(string what, bit [63:0] got, bit [63:0] want);
			$display("mismatch %s: got %h want %h", what, got, want);
			errors++;
		endtask

		task check(out_item_t o);
			out_item_t w;
			if (tx_due.size() == 0) begin
				report("unexpected item", o.tx_root_id, 64'd0);
				return;
			end
			w = tx_due.pop_front();
			if (o.tx_port != w.tx_port)
				report("tx_port", 64'(o.tx_port), 64'(w.tx_port));
			if (o.tx_root_id != w.tx_root_id) report("tx_root_id", o.tx_root_id, w.tx_root_id);
			if (o.tx_root_cost != w.tx_root_cost)
				report("tx_root_cost", 64'(o.tx_root_cost), 64'(w.tx_root_cost));
			if (o.tx_port_id != w.tx_port_id)
				report("tx_port_id", 64'(o.tx_port_id), 64'(w.tx_port_id));
			if (o.is_root_bridge != w.is_root_bridge)
				report("is_root_bridge", 64'(o.is_root_bridge), 64'(w.is_root_bridge));
			if (o.last != w.last) report("last", 64'(o.last), 64'(w.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	stp_predictor sb = new();
	int  sent;
	bit  quiet;
	bit  long_hold;
	int  idle_cycles;

	spanning_tree_config_bpdu_engine i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: random stall bursts, one long hold-off for back-pressure
	always begin
		@(negedge clk);
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (long_hold) begin
			out_stall <= 1'b1;
			repeat (400) @(negedge clk);
			long_hold = 0;
			out_stall <= 1'b0;
		end else begin
			out_stall <= $urandom_range(0, 2) == 0;
			repeat ($urandom_range(1, 10) - 1) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) sb.check(out_data);
		if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles > 5000) begin
			$display("tb_spanning_tree_config_bpdu_engine: errors");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_item(in_item_t it);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
		sent++;
		if (sent >= 280) quiet = 1;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10) - 1) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.tx_due.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic in_item_t make_rx(int p, bit [63:0] r, bit [31:0] c,
			bit [63:0] b, bit [15:0] id);
		in_item_t it;
		it.operation = OP_RX_CONFIG;
		it.rx_port = p[2:0];
		it.rx_root_id = r;
		it.rx_root_cost = c;
		it.rx_bridge_id = b;
		it.rx_port_id = id;
		return it;
	endfunction

	function automatic bit [63:0] pick_id();
		case ($urandom_range(0, 5))
			0: return 64'd0;
			1: return 64'($urandom_range(1, 4));
			2: return sb.bid;
			3: return sb.bid - 64'($urandom_range(1, 3));
			4: return sb.bid + 64'($urandom_range(1, 3));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		bit [31:0] c;
		int p;
		if ($urandom_range(0, 19) == 0) begin
			it = $bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom});
			return it;
		end
		p = $urandom_range(0, 7);
		case ($urandom_range(0, 3))
			0: c = 32'hFFFF_FFFF - $urandom_range(0, 3);
			1: c = $urandom;
			default: c = $urandom_range(0, 20);
		endcase
		it = make_rx(p, pick_id(), c, pick_id(),
			$urandom_range(0, 1) ? sb.ident(p) : 16'($urandom));
		if ($urandom_range(0, 7) == 0) it.operation = OP_HELLO;
		return it;
	endfunction

	initial begin
		bit [63:0] bids[6];
		bit [3:0]  nps[6];
		bit [7:0]  prs[6];
		bit [15:0] lcs[6];
		in_item_t  it;
		sb.set_reg(REG_BRIDGE_ID, RST_BRIDGE_ID);
		sb.set_reg(REG_PORTS, RST_PORTS);
		sb.set_reg(REG_PRIO, RST_PRIO);
		sb.set_reg(REG_LINK_COST, RST_LINK_COST);
		bids = '{64'h8000_0000_0000_1234, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF,
			{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}};
		nps = '{4'd8, 4'd1, 4'd15, 4'd0, 4'($urandom_range(2, 7)), 4'($urandom_range(9, 14))};
		prs = '{8'd128, 8'd0, 8'd255, 8'($urandom), 8'($urandom), 8'($urandom)};
		lcs = '{16'd1, 16'd0, 16'hFFFF, 16'($urandom), 16'($urandom), 16'($urandom)};
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// straight after reset: defaults in force
		it = '0;
		it.operation = OP_HELLO;
		send_item(it);
		send_item(make_rx(3, 64'd0, 32'd0, 64'd0, 16'd0));
		send_item(it);
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_BRIDGE_ID, bids[ph]);
			write_reg(REG_PORTS, nps[ph]);
			write_reg(REG_PRIO, prs[ph]);
			write_reg(REG_LINK_COST, lcs[ph]);
			if (ph == 0) begin
				it.operation = OP_HELLO;
				send_item(it);
				send_item(make_rx(0, 64'd1, 32'd5, 64'd2, 16'hFFFF));
				send_item(make_rx(0, '1, '1, '1, '1));
				send_item(make_rx(7, 64'd0, 32'hFFFF_FFFF, 64'd3, 16'd0));
				send_item(make_rx(5, 64'd0, 32'hFFFF_FFFF, 64'd3, 16'd0));
				send_item(make_rx(2, 64'd1, 32'd4, 64'd9, 16'd1));
				send_item(it);
				// own vector arriving on a port: stored, yet the port still counts as designated
				send_item(make_rx(1, 64'd0, 32'd0, sb.bid, sb.ident(1)));
				send_item(make_rx(4, 64'd0, 32'd0, 64'd0, 16'd0));
				send_item(it);
			end
			if (ph == 2) long_hold = 1;
			repeat (50) send_item(rand_item());
			wait_idle();
		end

		if (sb.errors == 0) begin
			$display("tb_spanning_tree_config_bpdu_engine: clean");
		end else begin
			$display("tb_spanning_tree_config_bpdu_engine: errors");
		end
		$finish;
	end
endmodule

### files.f
rtl/stcb_pkg.sv
rtl/stcb_vec_store.sv
rtl/spanning_tree_config_bpdu_engine.sv
rtl/stcb_checker.sv
bench/tb_spanning_tree_config_bpdu_engine.sv
